/* design/pcpp_pkg.sv */
// Shared types, constants and helper functions of the palette/cursor pixel path.
`default_nettype none
package pcpp_pkg;

    // Table geometry
    localparam int PALETTE_COUNT   = 32;
    localparam int PALETTE_ENTRIES = 256;
    localparam int CURSOR_SIZE     = 32;

    localparam int PAL_DEPTH    = PALETTE_COUNT * PALETTE_ENTRIES;
    localparam int PAL_AW       = $clog2(PAL_DEPTH);
    localparam int ROW_WORDS    = (CURSOR_SIZE + 15) / 16;
    localparam int BITMAP_WORDS = CURSOR_SIZE * ROW_WORDS;
    localparam int BM_AW        = $clog2(BITMAP_WORDS);

    // Item opcodes
    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_PAL_WR = 2'd1;
    localparam logic [1:0] OP_CUR_WR = 2'd2;

    // Colour modes
    localparam logic [2:0] MODE_INDEXED = 3'd0;
    localparam logic [2:0] MODE_RGB332  = 3'd1;
    localparam logic [2:0] MODE_DIRECT  = 3'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLOR_MODE     = 3'd0;
    localparam logic [2:0] CFG_PALETTE_SELECT = 3'd1;
    localparam logic [2:0] CFG_CURSOR_CONTROL = 3'd2;
    localparam logic [2:0] CFG_CURSOR_X       = 3'd3;
    localparam logic [2:0] CFG_CURSOR_Y       = 3'd4;
    localparam logic [2:0] CFG_CURSOR_COLOR_A = 3'd5;
    localparam logic [2:0] CFG_CURSOR_COLOR_B = 3'd6;
    localparam logic [2:0] CFG_CURSOR_COLOR_C = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] raw_color;
        logic [12:0] table_index;
        logic [31:0] table_data;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       cursor_hit;
        logic       mode_error;
    } t_pix_out;

    // Reduce a palette select to the palette count by binary long division.
    function automatic logic [4:0] pal_wrap(input logic [4:0] sel);
        logic [9:0] v;
        v = {5'b0, sel};
        for (int k = 4; k >= 0; k--) begin
            if (v >= 10'(PALETTE_COUNT << k)) begin
                v = v - 10'(PALETTE_COUNT << k);
            end
        end
        return v[4:0];
    endfunction

    // 3-bit channel to 8 bits: v * 255 / 7, truncated
    function automatic logic [7:0] expand3(input logic [2:0] v);
        logic [7:0] r;
        case (v)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd36;
            3'd2:    r = 8'd72;
            3'd3:    r = 8'd109;
            3'd4:    r = 8'd145;
            3'd5:    r = 8'd182;
            3'd6:    r = 8'd218;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    // 2-bit channel to 8 bits: v * 85
    function automatic logic [7:0] expand2(input logic [1:0] v);
        logic [7:0] r;
        case (v)
            2'd0:    r = 8'd0;
            2'd1:    r = 8'd85;
            2'd2:    r = 8'd170;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/palette_cursor_pixel_path_core.sv */
// Top level of the palette/cursor pixel path: config registers, pixel pipeline, output register.
`default_nettype none
// Display pixel path. Each input transaction is a pixel, a palette entry write or a
// cursor bitmap word write; only pixels produce an output transaction, carrying 8-bit
// red, green and blue plus cursor_hit and mode_error. While the output is not stalled,
// the block takes one transaction per clock and sustains one pixel per clock. The
// accept edge issues the palette and bitmap reads and registers the pixel context in
// stage 1; when stage 1 moves, the colour after mode conversion and cursor overlay is
// registered into the output register, which presents the result. Table writes go to
// memory at the accept edge and are visible to a pixel accepted on the very next
// cycle, so no interlock is needed. Backpressure on the output stalls the pipeline
// stage and, through it, the input ready. The cursor bitmap reads as zero after reset
// (one valid flop per word, no clearing pass); a palette entry must be written before
// any pixel reads it. Configuration is written through a plain write port and must
// only change while no pixel is in flight.
module palette_cursor_pixel_path_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [23:0]       i_cfg_wdata,
    // input items
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pcpp_pkg::t_pix_in i_in_data,
    // results
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pcpp_pkg::t_pix_out     o_out_data
);
    import pcpp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]         r_color_mode;
    logic [4:0]         r_palette_select;
    logic [1:0]         r_cursor_control;
    logic signed [15:0] r_cursor_x;
    logic signed [15:0] r_cursor_y;
    logic [23:0]        r_color_a;
    logic [23:0]        r_color_b;
    logic [23:0]        r_color_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode     <= '0;
            r_palette_select <= '0;
            r_cursor_control <= '0;
            r_cursor_x       <= '0;
            r_cursor_y       <= '0;
            r_color_a        <= '0;
            r_color_b        <= '0;
            r_color_c        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLOR_MODE:     r_color_mode     <= i_cfg_wdata[2:0];
                CFG_PALETTE_SELECT: r_palette_select <= i_cfg_wdata[4:0];
                CFG_CURSOR_CONTROL: r_cursor_control <= i_cfg_wdata[1:0];
                CFG_CURSOR_X:       r_cursor_x       <= i_cfg_wdata[15:0];
                CFG_CURSOR_Y:       r_cursor_y       <= i_cfg_wdata[15:0];
                CFG_CURSOR_COLOR_A: r_color_a        <= i_cfg_wdata;
                CFG_CURSOR_COLOR_B: r_color_b        <= i_cfg_wdata;
                CFG_CURSOR_COLOR_C: r_color_c        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_go;
    logic in_acc;
    logic pix_acc;

    // stage 1 moves when the output register is empty or being drained
    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pix_acc    = in_acc && (i_in_data.opcode == OP_PIXEL);

    // ------------------------------------------------------------------
    // Stage 0: address generation and crosshair/window compare
    // ------------------------------------------------------------------
    logic [4:0]        pal_sel;
    logic [12:0]       pal_full;
    logic [PAL_AW-1:0] pal_raddr;
    logic              pal_we;
    logic              cur_we;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] px_s;
    logic signed [16:0] py_s;
    logic signed [16:0] cx_s;
    logic signed [16:0] cy_s;
    logic [16:0]       bm_full;
    logic [BM_AW-1:0]  bm_raddr;
    logic              in_win;
    logic              xhair;

    assign pal_sel   = pal_wrap(r_palette_select);
    assign pal_full  = 13'({8'd0, pal_sel} * PALETTE_ENTRIES) + {5'd0, i_in_data.raw_color[7:0]};
    assign pal_raddr = pal_full[PAL_AW-1:0];

    // drop table writes that fall outside the store
    assign pal_we = in_acc && (i_in_data.opcode == OP_PAL_WR)
                    && ({1'b0, i_in_data.table_index} < 14'(PAL_DEPTH));
    assign cur_we = in_acc && (i_in_data.opcode == OP_CUR_WR)
                    && ({1'b0, i_in_data.table_index} < 14'(BITMAP_WORDS));

    assign px_s = {5'd0, i_in_data.pixel_x};
    assign py_s = {5'd0, i_in_data.pixel_y};
    assign cx_s = {r_cursor_x[15], r_cursor_x};
    assign cy_s = {r_cursor_y[15], r_cursor_y};
    assign dx   = px_s - cx_s;
    assign dy   = py_s - cy_s;

    assign in_win = (dx >= 17'sd0) && (dx < 17'(CURSOR_SIZE))
                    && (dy >= 17'sd0) && (dy < 17'(CURSOR_SIZE));
    assign xhair  = (px_s == cx_s) || (py_s == cy_s);

    // word = row * words-per-row + column / 16
    assign bm_full  = 17'(dy * ROW_WORDS) + 17'(dx >>> 4);
    assign bm_raddr = bm_full[BM_AW-1:0];

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [23:0] pal_rdata;
    logic [31:0] bm_rdata;

    pcpp_pal_mem u_pal_mem (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_in_data.table_index[PAL_AW-1:0]),
        .i_wdata (i_in_data.table_data[31:8]),
        .i_re    (pix_acc),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    pcpp_cur_mem u_cur_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (cur_we),
        .i_waddr (i_in_data.table_index[BM_AW-1:0]),
        .i_wdata (i_in_data.table_data),
        .i_re    (pix_acc),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 registers: pixel context alongside the memory read data
    // ------------------------------------------------------------------
    logic [31:0] r_s1_raw;
    logic        r_s1_win;
    logic        r_s1_xhair;
    logic [3:0]  r_s1_nib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_raw   <= i_in_data.raw_color;
            r_s1_win   <= in_win;
            r_s1_xhair <= xhair;
            r_s1_nib   <= dx[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: colour conversion then cursor overlay
    // ------------------------------------------------------------------
    logic [23:0] base_rgb;
    logic        mode_err;
    logic [31:0] bm_shift;
    logic [1:0]  code;
    logic        hit;
    logic [23:0] cur_rgb;
    t_pix_out    n_out;

    always_comb begin
        mode_err = 1'b0;
        unique case (r_color_mode)
            MODE_INDEXED: base_rgb = pal_rdata;
            MODE_RGB332:  base_rgb = {expand3(r_s1_raw[7:5]), expand3(r_s1_raw[4:2]),
                                      expand2(r_s1_raw[1:0])};
            MODE_DIRECT:  base_rgb = r_s1_raw[31:8];
            default: begin
                base_rgb = 24'd0;
                mode_err = 1'b1;
            end
        endcase
    end

    // leftmost pixel of a word sits in the top two bits
    assign bm_shift = bm_rdata >> {~r_s1_nib, 1'b0};

    always_comb begin
        code    = r_s1_win ? bm_shift[1:0] : 2'd0;
        hit     = 1'b0;
        cur_rgb = r_color_a;
        if (r_cursor_control[0]) begin
            if (r_cursor_control[1]) begin
                hit = r_s1_xhair;
            end else begin
                hit = (code != 2'd0);
                case (code)
                    2'd2:    cur_rgb = r_color_b;
                    2'd3:    cur_rgb = r_color_c;
                    default: cur_rgb = r_color_a;
                endcase
            end
        end
        n_out.red        = hit ? cur_rgb[23:16] : base_rgb[23:16];
        n_out.green      = hit ? cur_rgb[15:8]  : base_rgb[15:8];
        n_out.blue       = hit ? cur_rgb[7:0]   : base_rgb[7:0];
        n_out.cursor_hit = hit;
        n_out.mode_error = mode_err;
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until taken
    // ------------------------------------------------------------------
    t_pix_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

/* design/pcpp_pal_mem.sv */
// Palette memory: one write port, one registered read port.
`default_nettype none
module pcpp_pal_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [pcpp_pkg::PAL_AW-1:0] i_waddr,
    input  wire logic [23:0]               i_wdata,
    input  wire logic                      i_re,
    input  wire logic [pcpp_pkg::PAL_AW-1:0] i_raddr,
    output logic [23:0]                    o_rdata
);
    import pcpp_pkg::*;

    logic [23:0] r_mem [PAL_DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/pcpp_cur_mem.sv */
// Cursor bitmap memory with per-word valid bits so unwritten words read as zero.
`default_nettype none
module pcpp_cur_mem (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [pcpp_pkg::BM_AW-1:0] i_waddr,
    input  wire logic [31:0]              i_wdata,
    input  wire logic                     i_re,
    input  wire logic [pcpp_pkg::BM_AW-1:0] i_raddr,
    output logic [31:0]                   o_rdata
);
    import pcpp_pkg::*;

    logic [31:0]             r_mem [BITMAP_WORDS];
    logic [BITMAP_WORDS-1:0] r_vld;
    logic [31:0]             r_rdata;
    logic                    r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 32'd0;

endmodule
`default_nettype wire
